// ----- rtl/prbt_pkg.sv -----
// prbt_pkg: widths, register map, config and result types shared by the
// periodic reset backoff tracker modules
// no dependencies
`timescale 1ns / 1ps

package prbt_pkg;

	localparam int TIME_BITS_DEF = 48;
	localparam int TS_W          = 48;
	localparam int BACKOFF_W     = 26;
	localparam int RUN_W         = 8;
	localparam int TOL_W         = 20;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int IN_TDATA_W    = 48;
	localparam int OUT_TDATA_W   = 40;

	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// register indexes, byte address is 4 * index
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_TOLERANCE = 3'd1;
	localparam logic [2:0] REG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_INITIAL   = 3'd3;
	localparam logic [2:0] REG_MAXIMUM   = 3'd4;
	localparam logic [2:0] REG_FLOOR     = 3'd5;

	// request kinds
	localparam logic KIND_OBSERVE = 1'b0;
	localparam logic KIND_GRANT   = 1'b1;

	localparam logic [TOL_W-1:0]     RST_TOLERANCE = TOL_W'(5000);
	localparam logic [RUN_W-1:0]     RST_THRESHOLD = RUN_W'(6);
	localparam logic [BACKOFF_W-1:0] RST_INITIAL   = BACKOFF_W'(250000);
	localparam logic [BACKOFF_W-1:0] RST_MAXIMUM   = BACKOFF_W'(30000000);
	localparam logic [BACKOFF_W-1:0] RST_FLOOR     = BACKOFF_W'(1000);

	typedef struct packed {
		logic                 enable;
		logic [TOL_W-1:0]     gap_tolerance_us;
		logic [RUN_W-1:0]     pattern_threshold;
		logic [BACKOFF_W-1:0] initial_backoff_us;
		logic [BACKOFF_W-1:0] max_backoff_us;
		logic [BACKOFF_W-1:0] halve_floor_us;
	} cfg_t;

	typedef struct packed {
		logic                 pattern_active;
		logic [RUN_W-1:0]     run_count;
		logic [BACKOFF_W-1:0] backoff_us;
	} res_t;

endpackage

// ----- rtl/prbt_cfg.sv -----
// prbt_cfg: APB-style configuration register file
// depends on prbt_pkg
`timescale 1ns / 1ps

module prbt_cfg
	import prbt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable             <= 1'b0;
			cfg_q.gap_tolerance_us   <= RST_TOLERANCE;
			cfg_q.pattern_threshold  <= RST_THRESHOLD;
			cfg_q.initial_backoff_us <= RST_INITIAL;
			cfg_q.max_backoff_us     <= RST_MAXIMUM;
			cfg_q.halve_floor_us     <= RST_FLOOR;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLE:    cfg_q.enable             <= pwdata[0];
				REG_TOLERANCE: cfg_q.gap_tolerance_us   <= pwdata[TOL_W-1:0];
				REG_THRESHOLD: cfg_q.pattern_threshold  <= pwdata[RUN_W-1:0];
				REG_INITIAL:   cfg_q.initial_backoff_us <= pwdata[BACKOFF_W-1:0];
				REG_MAXIMUM:   cfg_q.max_backoff_us     <= pwdata[BACKOFF_W-1:0];
				REG_FLOOR:     cfg_q.halve_floor_us     <= pwdata[BACKOFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ENABLE:    prdata = DATA_W'(cfg_q.enable);
			REG_TOLERANCE: prdata = DATA_W'(cfg_q.gap_tolerance_us);
			REG_THRESHOLD: prdata = DATA_W'(cfg_q.pattern_threshold);
			REG_INITIAL:   prdata = DATA_W'(cfg_q.initial_backoff_us);
			REG_MAXIMUM:   prdata = DATA_W'(cfg_q.max_backoff_us);
			REG_FLOOR:     prdata = DATA_W'(cfg_q.halve_floor_us);
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- rtl/prbt_core.sv -----
// prbt_core: tracker state and the single-pass update for one request
// depends on prbt_pkg
`timescale 1ns / 1ps

module prbt_core
	import prbt_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 kind,
	input  logic [TIME_BITS-1:0] now,
	input  cfg_t                 cfg,
	output res_t                 res
);

	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [RUN_W-1:0]     run_q;
	logic [BACKOFF_W-1:0] backoff_q;

	logic                 obs_en;
	logic                 grant_en;
	logic                 have_last;
	logic [TIME_BITS-1:0] gap;
	logic [TIME_BITS-1:0] diff;
	logic                 in_tol;
	logic [RUN_W-1:0]     run_obs;
	logic [TIME_BITS-1:0] prev_next;
	logic                 active_obs;
	logic [BACKOFF_W:0]   grown;
	logic [BACKOFF_W-1:0] clamped;
	logic [BACKOFF_W-1:0] backoff_obs;
	logic [BACKOFF_W-1:0] backoff_grant;
	logic [RUN_W-1:0]     run_shown;

	assign obs_en    = cfg.enable & (kind == KIND_OBSERVE);
	assign grant_en  = cfg.enable & (kind == KIND_GRANT);
	assign have_last = (last_q != '0);
	assign gap       = now - last_q;
	assign diff      = (gap >= prev_q) ? (gap - prev_q) : (prev_q - gap);
	assign in_tol    = (diff <= TIME_BITS'(cfg.gap_tolerance_us));

	always_comb begin
		run_obs = run_q;
		if (have_last && (prev_q != '0)) begin
			if (in_tol)
				run_obs = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
			else
				run_obs = '0;
		end
	end

	assign prev_next  = have_last ? gap : prev_q;
	assign active_obs = (run_obs >= cfg.pattern_threshold);

	// first step loads the initial value, later steps double, then clamp
	assign grown = (backoff_q == '0) ? {1'b0, cfg.initial_backoff_us} : {backoff_q, 1'b0};
	assign clamped = (grown > {1'b0, cfg.max_backoff_us}) ? cfg.max_backoff_us
							      : grown[BACKOFF_W-1:0];
	assign backoff_obs   = active_obs ? clamped : backoff_q;
	assign backoff_grant = (backoff_q > cfg.halve_floor_us) ? (backoff_q >> 1) : backoff_q;

	assign run_shown = obs_en ? run_obs : run_q;

	always_comb begin
		res.run_count      = run_shown;
		res.pattern_active = (run_shown >= cfg.pattern_threshold);
		if (obs_en)
			res.backoff_us = backoff_obs;
		else if (grant_en)
			res.backoff_us = backoff_q;
		else
			res.backoff_us = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			prev_q    <= '0;
			run_q     <= '0;
			backoff_q <= '0;
		end else if (upd) begin
			if (obs_en) begin
				last_q    <= now;
				prev_q    <= prev_next;
				run_q     <= run_obs;
				backoff_q <= backoff_obs;
			end else if (grant_en) begin
				backoff_q <= backoff_grant;
			end
		end
	end

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !cfg.enable |=> $stable(last_q) && $stable(prev_q) && $stable(run_q)
			&& $stable(backoff_q))
		else $error("state changed while disabled");

	a_grant_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		upd && grant_en |=> backoff_q <= $past(backoff_q))
		else $error("grant raised the backoff");

	a_grant_keeps_run: assert property (@(posedge clk) disable iff (!arst_n)
		upd && grant_en |=> $stable(run_q) && $stable(last_q) && $stable(prev_q))
		else $error("grant touched reset tracking");

	a_run_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		upd && obs_en && run_q == RUN_MAX |=> run_q == RUN_MAX || run_q == '0)
		else $error("run counter wrapped");

endmodule

// ----- rtl/periodic_reset_backoff_tracker.sv -----
// periodic_reset_backoff_tracker: top level with request register, core and result register
// depends on prbt_pkg, prbt_cfg, prbt_core
//
//  channel  | group                                  | contents
//  request  | s_tvalid s_tready s_tdata s_tuser      | timestamp_us, req_type
//  result   | m_tvalid m_tready m_tdata              | backoff_us, run_count, pattern_active
//  config   | psel penable pwrite paddr pwdata prdata pready | six registers at 4*i
//
// one request per cycle sustained while m_tready stays high
// the request register feeds the core, whose state updates as the result register loads
// a stalled result register holds the request register, which still takes a request if empty
// arst_n clears tracking state, valid flags and config registers to their reset values
`timescale 1ns / 1ps

module periodic_reset_backoff_tracker
	import prbt_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [47:0] timestamp_us
	input  logic                   s_tuser,   // [0] req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [25:0] backoff_us, [33:26] run_count,
	                                          // [34] pattern_active, [39:35] zero
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	logic             kind_s1;
	logic [TS_W-1:0]  ts_s1;
	logic             valid_s2;
	res_t             res_s2;
	logic             advance;
	logic             take;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign take     = s_tvalid & s_tready;

	prbt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prbt_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.kind   (kind_s1),
		.now    (TIME_BITS'(ts_s1)),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= s_tuser;
			ts_s1   <= s_tdata[TS_W-1:0];
		end
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'({res_s2.pattern_active, res_s2.run_count,
					res_s2.backoff_us});

	a_stall_keeps_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("request dropped while result stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !advance)
		else $error("pending result overwritten");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced request produced no result");

endmodule
